[rtl/dlar_pkg.sv]
// Package for the display-list address relocator.
// Holds the opcodes, command codes, field widths and the structs that the
// modules and interfaces share. Depends on nothing.
package dlar_pkg;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 64;
    localparam int OFF_W   = 24;
    localparam int OP_W    = 8;
    localparam int SEG_W   = 4;
    localparam int CFG_IDX_W = 1;

    // Action codes carried in the command field.
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REWRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BASE = 1'd1;

    // Display-list opcodes, taken from bits 63:56.
    localparam logic [OP_W-1:0] OP_MTX      = 8'h01;
    localparam logic [OP_W-1:0] OP_MOVEMEM  = 8'h03;
    localparam logic [OP_W-1:0] OP_VTX      = 8'h04;
    localparam logic [OP_W-1:0] OP_DL       = 8'h06;
    localparam logic [OP_W-1:0] OP_COL      = 8'h07;
    localparam logic [OP_W-1:0] OP_ENDDL    = 8'hb8;
    localparam logic [OP_W-1:0] OP_MOVEWORD = 8'hbc;
    localparam logic [OP_W-1:0] OP_SETTIMG  = 8'hfd;
    localparam logic [OP_W-1:0] OP_SETZIMG  = 8'hfe;
    localparam logic [OP_W-1:0] OP_SETCIMG  = 8'hff;

    // Segment whose offsets get relocated.
    localparam logic [SEG_W-1:0] SEG_RELOC = 4'd5;

    // Lookup token that walks the chain of table cells.
    typedef struct packed {
        logic             vld;
        logic [OFF_W-1:0] key;
        logic             found;
        logic [OFF_W-1:0] data;
    } t_tok;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              end_of_list;
        logic              range_error;
        logic              table_full;
    } t_result;

endpackage

[rtl/dlar_if.sv]
// Handshake interfaces for the display-list address relocator: the input
// item channel, the result channel and the configuration write channel.
// Depends on dlar_pkg.
interface dlar_in_if;
    import dlar_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [WORD_W-1:0]    cmd_word;
    logic [OFF_W-1:0]     map_source;
    logic [OFF_W-1:0]     map_dest;

    modport source(output valid, command, cmd_word, map_source, map_dest, input ready);
    modport sink(input valid, command, cmd_word, map_source, map_dest, output ready);
endinterface

interface dlar_out_if;
    import dlar_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    out_word;
    logic                 end_of_list;
    logic                 range_error;
    logic                 table_full;

    modport source(output valid, out_word, end_of_list, range_error, table_full,
                   input ready);
    modport sink(input valid, out_word, end_of_list, range_error, table_full,
                 output ready);
endinterface

interface dlar_cfg_if;
    import dlar_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [OFF_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/display_list_address_relocator.sv]
// Top level of the display-list address relocator: control, configuration,
// the chain of texture table cells and the result registers.
// Depends on dlar_pkg, dlar_if, dlar_cell and dlar_rewrite.
//
//   Channel  Port   Direction  Moves
//   -------  -----  ---------  ----------------------------------------------
//   input    i_in   sink       one item: command, cmd_word, map_source, map_dest
//   result   o_out  source     one item per input: out_word and three flags
//   config   i_cfg  sink       register index and 24-bit data, always ready
//
// An item is accepted and computed into the pending stage, then moved into
// the output register. A set-texture-image with segment 5 sends a token down
// the table chain, one cell a cycle, and its result then enters the pending stage.
// Reset clears the entry count, the config registers and all valid flags; the
// table entries themselves hold whatever they held. A stalled result holds in
// the output register while the next item is accepted into the pending stage.
module display_list_address_relocator #(
    parameter int TEX_TABLE_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dlar_in_if.sink       i_in,
    dlar_out_if.source    o_out,
    dlar_cfg_if.sink      i_cfg
);
    import dlar_pkg::*;

    localparam int CNT_W = $clog2(TEX_TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TEX_TABLE_DEPTH);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic              r_state;
    logic              n_state;
    logic [OFF_W-1:0]  r_src_base;
    logic [OFF_W-1:0]  r_dst_base;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [WORD_W-1:0] r_word;
    logic              r_pend_vld;
    t_result           r_pend;
    logic              r_out_vld;
    t_result           r_out;

    logic              w_accept;
    logic              w_launch;
    logic              w_add_ok;
    logic              w_load;
    t_result           w_load_res;
    logic              w_move;
    logic [WORD_W-1:0] w_rw_word;
    logic [OFF_W-1:0]  w_tex_dst;
    t_result           w_rw_res;
    t_tok              w_tok [TEX_TABLE_DEPTH+1];

    // Configuration writes are taken at any time.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= '0;
            r_dst_base <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SRC_BASE: r_src_base <= i_cfg.data;
                CFG_DST_BASE: r_dst_base <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input handshake and action decode.
    assign i_in.ready = (r_state == ST_IDLE) && !r_pend_vld;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_launch   = w_accept && (i_in.command == CMD_REWRITE) &&
                        (i_in.cmd_word[63:56] == OP_SETTIMG) &&
                        (i_in.cmd_word[27:24] == SEG_RELOC);
    assign w_add_ok   = w_accept && (i_in.command == CMD_ADD) && (r_count < CNT_MAX);

    // Entry count.
    always_comb begin
        n_count = r_count;
        if (w_accept && (i_in.command == CMD_CLEAR)) begin
            n_count = '0;
        end else if (w_add_ok) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Chain of table cells; the token enters at cell 0 when a lookup starts.
    assign w_tok[0].vld   = w_launch;
    assign w_tok[0].key   = i_in.cmd_word[OFF_W-1:0];
    assign w_tok[0].found = 1'b0;
    assign w_tok[0].data  = '0;

    for (genvar g = 0; g < TEX_TABLE_DEPTH; g++) begin : g_cell
        dlar_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_entry_vld (CNT_W'(g) < r_count),
            .i_wr_en     (w_add_ok && (r_count == CNT_W'(g))),
            .i_wr_src    (i_in.map_source),
            .i_wr_dst    (i_in.map_dest),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g+1])
        );
    end

    // Word held while the token walks the chain.
    always_ff @(posedge i_clk) begin
        if (w_launch) begin
            r_word <= i_in.cmd_word;
        end
    end

    // One rewrite unit serves both the direct path and the lookup finish.
    assign w_rw_word = (r_state == ST_LOOKUP) ? r_word : i_in.cmd_word;
    assign w_tex_dst = w_tok[TEX_TABLE_DEPTH].found ? w_tok[TEX_TABLE_DEPTH].data : '0;

    dlar_rewrite u_rewrite (
        .i_word     (w_rw_word),
        .i_src_base (r_src_base),
        .i_dst_base (r_dst_base),
        .i_tex_dst  (w_tex_dst),
        .o_res      (w_rw_res)
    );

    // Sequencer and the result that goes into the pending stage.
    always_comb begin
        n_state    = r_state;
        w_load     = 1'b0;
        w_load_res = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_launch) begin
                    n_state = ST_LOOKUP;
                end else if (w_accept) begin
                    w_load = 1'b1;
                    case (i_in.command)
                        CMD_ADD:     w_load_res.table_full = (r_count >= CNT_MAX);
                        CMD_REWRITE: w_load_res = w_rw_res;
                        default:     w_load_res = '0;
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (w_tok[TEX_TABLE_DEPTH].vld) begin
                    w_load     = 1'b1;
                    w_load_res = w_rw_res;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pending stage feeds the output register when it is free.
    assign w_move = r_pend_vld && (!r_out_vld || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_move) begin
                r_pend_vld <= 1'b0;
            end else if (w_load) begin
                r_pend_vld <= 1'b1;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pend <= w_load_res;
        end
        if (w_move) begin
            r_out <= r_pend;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.out_word    = r_out.out_word;
    assign o_out.end_of_list = r_out.end_of_list;
    assign o_out.range_error = r_out.range_error;
    assign o_out.table_full  = r_out.table_full;

endmodule

[rtl/dlar_cell.sv]
// One cell of the texture mapping table: holds a source/destination pair and
// passes the lookup token on to its neighbor every cycle.
// Depends on dlar_pkg.
module dlar_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_entry_vld,
    input  logic                      i_wr_en,
    input  logic [dlar_pkg::OFF_W-1:0] i_wr_src,
    input  logic [dlar_pkg::OFF_W-1:0] i_wr_dst,
    input  dlar_pkg::t_tok            i_tok,
    output dlar_pkg::t_tok            o_tok
);
    import dlar_pkg::*;

    logic [OFF_W-1:0] r_src;
    logic [OFF_W-1:0] r_dst;
    logic             r_tok_vld;
    logic [OFF_W-1:0] r_tok_key;
    logic             r_tok_found;
    logic [OFF_W-1:0] r_tok_data;
    logic             w_hit;

    // The first live entry that matches claims the token.
    assign w_hit = !i_tok.found && i_entry_vld && (r_src == i_tok.key);

    // Entry storage, written when the table appends at this cell.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_src <= i_wr_src;
            r_dst <= i_wr_dst;
        end
    end

    // Token valid is control state and resets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok.vld;
        end
    end

    // Token payload moves one cell per cycle.
    always_ff @(posedge i_clk) begin
        r_tok_key   <= i_tok.key;
        r_tok_found <= i_tok.found || w_hit;
        r_tok_data  <= w_hit ? r_dst : i_tok.data;
    end

    assign o_tok.vld   = r_tok_vld;
    assign o_tok.key   = r_tok_key;
    assign o_tok.found = r_tok_found;
    assign o_tok.data  = r_tok_data;

endmodule

[rtl/dlar_rewrite.sv]
// Command word rewrite: decodes the opcode, relocates segment 5 offsets and
// flags segmented and end-of-list opcodes. Depends on dlar_pkg.
module dlar_rewrite (
    input  logic [dlar_pkg::WORD_W-1:0] i_word,
    input  logic [dlar_pkg::OFF_W-1:0]  i_src_base,
    input  logic [dlar_pkg::OFF_W-1:0]  i_dst_base,
    input  logic [dlar_pkg::OFF_W-1:0]  i_tex_dst,
    output dlar_pkg::t_result           o_res
);
    import dlar_pkg::*;

    logic [OP_W-1:0]   w_op;
    logic [SEG_W-1:0]  w_seg;
    logic [OFF_W-1:0]  w_off;
    logic              w_has_addr;
    logic              w_segmented;
    logic [OFF_W-1:0]  w_new_off;
    logic              w_rerr;
    logic [WORD_W-1:0] w_word;

    assign w_op  = i_word[63:56];
    assign w_seg = i_word[27:24];
    assign w_off = i_word[OFF_W-1:0];

    assign w_has_addr = (w_op == OP_VTX) || (w_op == OP_COL) ||
                        (w_op == OP_MOVEWORD) || (w_op == OP_SETTIMG);

    assign w_segmented = (w_op == OP_MTX) || (w_op == OP_MOVEMEM) ||
                         (w_op == OP_VTX) || (w_op == OP_DL) ||
                         (w_op == OP_COL) || (w_op == OP_SETTIMG) ||
                         (w_op == OP_SETZIMG) || (w_op == OP_SETCIMG);

    // Offset relocation; rebasing wraps at 24 bits.
    always_comb begin
        w_new_off = w_off;
        w_rerr    = 1'b0;
        if (w_has_addr && (w_seg == SEG_RELOC)) begin
            if (w_op == OP_SETTIMG) begin
                w_new_off = i_tex_dst;
            end else if (w_off < i_src_base) begin
                w_rerr = 1'b1;
            end else begin
                w_new_off = w_off - i_src_base + i_dst_base;
            end
        end
    end

    // Reassemble the word and set bit 0 for segmented opcodes.
    always_comb begin
        w_word    = {i_word[WORD_W-1:OFF_W], w_new_off};
        w_word[0] = w_word[0] | w_segmented;
    end

    assign o_res.out_word    = w_word;
    assign o_res.end_of_list = (w_op == OP_ENDDL);
    assign o_res.range_error = w_rerr;
    assign o_res.table_full  = 1'b0;

endmodule

[verif/display_list_address_relocator_test.sv]
// Self-checking testbench for the display-list address relocator.
// Drives add, clear and rewrite items, predicts every result and compares it
// field by field. Depends on dlar_pkg, dlar_if and the RTL of the block.
`timescale 1ns / 100ps

module display_list_address_relocator_test;
    import dlar_pkg::*;

    localparam int TEX_DEPTH       = 64;
    localparam int LIMIT_CYCLES    = 600000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int MAX_REPORTS     = 10;
    localparam int DIR_N           = 27;
    localparam int DIR_CFG_ROW     = 19;

    // Command code that the block answers with an all-zero result and no other action.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [OFF_W-1:0] OFF_MAX    = 24'hff_ffff;

    // One row of stimulus; res is only meaningful when typed is set.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word;
        logic [OFF_W-1:0]  msrc;
        logic [OFF_W-1:0]  mdst;
        logic              typed;
        t_result           res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dlar_in_if  in_ch();
    dlar_out_if out_ch();
    dlar_cfg_if cfg_ch();

    display_list_address_relocator #(
        .TEX_TABLE_DEPTH(TEX_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the block state, kept in step at each accepted item.
    logic [OFF_W-1:0] src_base = '0;
    logic [OFF_W-1:0] dst_base = '0;
    logic [OFF_W-1:0] tex_keys [TEX_DEPTH];
    logic [OFF_W-1:0] tex_vals [TEX_DEPTH];
    int               tex_count = 0;

    t_result expected_results [$];
    int      errors    = 0;
    int      cycles    = 0;
    int      idle_pct  = 0;
    int      stall_pct = 0;

    // A typed expectation travels with the item that the sender presents.
    logic    item_typed;
    t_result item_result;

    t_row dir_rows [DIR_N];

    // Computes the result of one item and updates the shadow state.
    function automatic t_result relocate_item(input logic [CMD_W-1:0] cmd,
                                              input logic [WORD_W-1:0] word,
                                              input logic [OFF_W-1:0] msrc,
                                              input logic [OFF_W-1:0] mdst);
        t_result          r;
        logic [OP_W-1:0]  op;
        logic [OFF_W-1:0] off;
        logic             hit;
        int               i;
        r   = '0;
        op  = word[63:56];
        off = word[23:0];
        hit = 1'b0;
        case (cmd)
            CMD_ADD: begin
                if (tex_count >= TEX_DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    tex_keys[tex_count] = msrc;
                    tex_vals[tex_count] = mdst;
                    tex_count++;
                end
            end
            CMD_CLEAR: begin
                tex_count = 0;
            end
            CMD_REWRITE: begin
                if ((op == OP_VTX || op == OP_COL || op == OP_MOVEWORD ||
                     op == OP_SETTIMG) && word[27:24] == SEG_RELOC) begin
                    if (op == OP_SETTIMG) begin
                        // First matching entry wins; a miss maps to zero.
                        for (i = 0; i < tex_count; i++) begin
                            if (!hit && tex_keys[i] == off) begin
                                hit = 1'b1;
                                off = tex_vals[i];
                            end
                        end
                        if (!hit) off = '0;
                    end else if (off < src_base) begin
                        r.range_error = 1'b1;
                    end else begin
                        off = off - src_base + dst_base;
                    end
                    word[23:0] = off;
                end
                case (op)
                    OP_MTX, OP_MOVEMEM, OP_VTX, OP_DL, OP_COL,
                    OP_SETTIMG, OP_SETZIMG, OP_SETCIMG: word[0] = 1'b1;
                    default: ;
                endcase
                r.out_word    = word;
                r.end_of_list = (op == OP_ENDDL);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input t_result got, input t_result want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t %s: word %h/%h eol %b/%b rerr %b/%b full %b/%b (got/exp)",
                     $realtime, what, got.out_word, want.out_word,
                     got.end_of_list, want.end_of_list, got.range_error,
                     want.range_error, got.table_full, want.table_full);
        end
    endtask

    // Predicts at input acceptance and checks at result acceptance.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result predicted;
        if (in_ch.valid && in_ch.ready) begin
            predicted = relocate_item(in_ch.command, in_ch.cmd_word,
                                      in_ch.map_source, in_ch.map_dest);
            expected_results.push_back(item_typed ? item_result : predicted);
        end
        if (out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_word, out_ch.end_of_list, out_ch.range_error,
                    out_ch.table_full};
            if (expected_results.size() == 0) begin
                report("unexpected result", got, '0);
            end else if (got !== expected_results[0]) begin
                report("mismatch", got, expected_results[0]);
                void'(expected_results.pop_front());
            end else begin
                void'(expected_results.pop_front());
            end
        end
    end

    // Receiver with random back-pressure.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Presents one item after a random gap and holds it until accepted.
    task automatic send_item(input t_row row);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= row.cmd;
        in_ch.cmd_word   <= row.word;
        in_ch.map_source <= row.msrc;
        in_ch.map_dest   <= row.mdst;
        item_typed       <= row.typed;
        item_result      <= row.res;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stops the sender and waits until every result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes both base registers back to back; the block must be idle.
    task automatic write_bases(input logic [OFF_W-1:0] src, input logic [OFF_W-1:0] dst);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_SRC_BASE;
        cfg_ch.data  <= src;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        src_base = src;
        cfg_ch.index <= CFG_DST_BASE;
        cfg_ch.data  <= dst;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        dst_base = dst;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Add item; a quarter of them repeat a key already in the table.
    function automatic t_row make_add();
        t_row row;
        row      = '0;
        row.cmd  = CMD_ADD;
        row.word = rand_word();
        row.msrc = OFF_W'($urandom);
        row.mdst = OFF_W'($urandom);
        if (tex_count > 0 && $urandom_range(3) == 0) begin
            row.msrc = tex_keys[$urandom_range(tex_count - 1)];
        end
        return row;
    endfunction

    // Rewrite item biased toward relocated opcodes, segment 5 and offsets
    // that sit near the source base or hit the texture table.
    function automatic t_row make_rewrite();
        t_row             row;
        logic [OP_W-1:0]  op;
        logic [OFF_W-1:0] off;
        int               pick;
        row  = '0;
        row.cmd  = CMD_REWRITE;
        row.word = rand_word();
        row.msrc = OFF_W'($urandom);
        row.mdst = OFF_W'($urandom);
        op   = row.word[63:56];
        pick = $urandom_range(9);
        if (pick < 5) begin
            case ($urandom_range(3))
                0: op = OP_VTX;
                1: op = OP_COL;
                2: op = OP_MOVEWORD;
                default: op = OP_SETTIMG;
            endcase
        end else if (pick < 7) begin
            case ($urandom_range(5))
                0: op = OP_MTX;
                1: op = OP_MOVEMEM;
                2: op = OP_DL;
                3: op = OP_ENDDL;
                4: op = OP_SETZIMG;
                default: op = OP_SETCIMG;
            endcase
        end
        row.word[63:56] = op;
        if ($urandom_range(9) < 7) row.word[27:24] = SEG_RELOC;
        off = row.word[23:0];
        if (op == OP_SETTIMG && tex_count > 0 && $urandom_range(9) < 7) begin
            off = tex_keys[$urandom_range(tex_count - 1)];
        end else if ($urandom_range(9) < 4) begin
            off = src_base - 24'd2 + OFF_W'($urandom_range(4));
        end
        row.word[23:0] = off;
        return row;
    endfunction

    // Random phase: sequences of clear, adds and rewrites, with some noise.
    task automatic run_phase(input logic fill_first);
        t_row row;
        int   sent;
        int   n_add;
        int   n_rw;
        logic first;
        sent  = 0;
        first = 1'b1;
        while (sent < ITEMS_PER_PHASE) begin
            if (first || $urandom_range(9) != 0) begin
                row      = '0;
                row.cmd  = CMD_CLEAR;
                row.word = rand_word();
                row.msrc = OFF_W'($urandom);
                row.mdst = OFF_W'($urandom);
                send_item(row);
                sent++;
            end
            // A filling sequence overruns the table to provoke table full.
            n_add = (first && fill_first) ? TEX_DEPTH + 2 : $urandom_range(10);
            repeat (n_add) begin
                send_item(make_add());
                sent++;
            end
            n_rw = $urandom_range(4, 20);
            repeat (n_rw) begin
                if ($urandom_range(19) == 0) begin
                    row      = '0;
                    row.cmd  = CMD_W'($urandom_range(3));
                    row.word = rand_word();
                    row.msrc = OFF_W'($urandom);
                    row.mdst = OFF_W'($urandom);
                end else begin
                    row = make_rewrite();
                end
                send_item(row);
                sent++;
            end
            first = 1'b0;
        end
    endtask

    initial begin : stimulus
        logic [OFF_W-1:0] src;
        logic [OFF_W-1:0] dst;
        int               ph;
        int               r;

        // Directed rows; the first part runs with both bases at reset value.
        dir_rows[0]  = '{CMD_REWRITE, 64'h0, 24'h0, 24'h0, 1'b1, '{64'h0, 1'b0, 1'b0, 1'b0}};
        dir_rows[1]  = '{CMD_REWRITE, 64'hffff_ffff_ffff_ffff, 24'h0, 24'h0, 1'b1,
                         '{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0}};
        dir_rows[2]  = '{CMD_REWRITE, 64'hb800_0000_0000_0000, 24'h0, 24'h0, 1'b1,
                         '{64'hb800_0000_0000_0000, 1'b1, 1'b0, 1'b0}};
        dir_rows[3]  = '{CMD_UNUSED, 64'hffff_ffff_ffff_ffff, OFF_MAX, OFF_MAX, 1'b1, '0};
        dir_rows[4]  = '{CMD_ADD, 64'h0, 24'h000005, OFF_MAX, 1'b1, '0};
        dir_rows[5]  = '{CMD_ADD, 64'h0, OFF_MAX, 24'h000000, 1'b1, '0};
        dir_rows[6]  = '{CMD_ADD, 64'h0, 24'h000005, 24'h123456, 1'b1, '0};
        dir_rows[7]  = '{CMD_REWRITE, 64'hfd00_0000_0500_0005, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[8]  = '{CMD_REWRITE, 64'hfd00_0000_05ff_ffff, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[9]  = '{CMD_REWRITE, 64'hfd00_0000_0500_0007, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[10] = '{CMD_REWRITE, 64'hfd00_0000_0400_0005, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[11] = '{CMD_REWRITE, 64'h0400_1234_0512_3456, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[12] = '{CMD_REWRITE, 64'h07ff_ffff_05ff_fffe, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[13] = '{CMD_REWRITE, 64'hbc00_0006_0500_0010, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[14] = '{CMD_REWRITE, 64'h0100_0040_0000_0000, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[15] = '{CMD_REWRITE, 64'h0300_0000_0500_0000, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[16] = '{CMD_REWRITE, 64'h0600_0000_0500_0002, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[17] = '{CMD_REWRITE, 64'hfe00_0000_0500_0000, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[18] = '{CMD_REWRITE, 64'hff00_0000_0f00_0000, 24'h0, 24'h0, 1'b0, '0};
        // From here the source base is 0x400000 and the dest base is all ones.
        dir_rows[19] = '{CMD_REWRITE, 64'h0400_0000_053f_ffff, 24'h0, 24'h0, 1'b1,
                         '{64'h0400_0000_053f_ffff, 1'b0, 1'b1, 1'b0}};
        dir_rows[20] = '{CMD_REWRITE, 64'h0400_0000_0540_0000, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[21] = '{CMD_REWRITE, 64'hbc00_0000_0500_0000, 24'h0, 24'h0, 1'b1,
                         '{64'hbc00_0000_0500_0000, 1'b0, 1'b1, 1'b0}};
        dir_rows[22] = '{CMD_REWRITE, 64'h0700_0000_05ff_ffff, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[23] = '{CMD_REWRITE, 64'hfd00_0000_0500_0000, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[24] = '{CMD_CLEAR, 64'hffff_ffff_ffff_ffff, OFF_MAX, OFF_MAX, 1'b1, '0};
        dir_rows[25] = '{CMD_REWRITE, 64'hfd00_0000_05ff_ffff, 24'h0, 24'h0, 1'b0, '0};
        dir_rows[26] = '{CMD_ADD, 64'hffff_ffff_ffff_ffff, OFF_MAX, OFF_MAX, 1'b1, '0};

        // Every input starts at a known value.
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_ADD;
        in_ch.cmd_word   <= '0;
        in_ch.map_source <= '0;
        in_ch.map_dest   <= '0;
        item_typed       <= 1'b0;
        item_result      <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_SRC_BASE;
        cfg_ch.data      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        for (r = 0; r < DIR_N; r++) begin
            if (r == DIR_CFG_ROW) begin
                drain();
                write_bases(24'h40_0000, OFF_MAX);
            end
            send_item(dir_rows[r]);
        end

        // Random phases, each with its own base setting and one of four idle and stall patterns.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin src = 24'h00_0000; dst = OFF_MAX;     end
                1: begin src = OFF_MAX;     dst = 24'h00_0000; end
                2: begin src = 24'h80_0000; dst = 24'h00_0100; end
                4: begin src = OFF_MAX;     dst = OFF_MAX;     end
                5: begin src = 24'h00_0000; dst = 24'h00_0000; end
                7: begin src = 24'h00_0001; dst = 24'h7f_ffff; end
                default: begin src = OFF_W'($urandom); dst = OFF_W'($urandom); end
            endcase
            drain();
            write_bases(src, dst);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            run_phase(ph % 2 == 0);
        end

        // Let the last results come back, then allow a full lookup of slack.
        drain();
        repeat (TEX_DEPTH + 8) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
